// ===== sv/sdf_pkg.sv =====
// Shared types and constants for the square-drawing framebuffer.
// No dependencies; every other file refers to it by scoped names.
package sdf_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int SIDE_W      = 9;
  localparam int COORD_W     = 8;
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] MODE_OUTLINE = 2'd1;
  localparam logic [1:0] MODE_FILLED  = 2'd2;

  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_BOUNDS = 2'd1;
  localparam logic [1:0] STATUS_MODE   = 2'd2;

  localparam logic CFG_IMAGE_SIDE = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic [6:0] half_size;
    logic [7:0] paint_level;
    logic [1:0] fill_mode;
  } sdf_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_level;
  } sdf_out_t;

  typedef enum logic [1:0] {
    JOB_RESULT,
    JOB_PAINT,
    JOB_READ
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [1:0]         status;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [7:0]         level;
    logic               outline;
  } sdf_job_t;

endpackage

// ===== sv/sdf_front.sv =====
// Front end: configuration registers, item acceptance and classification.
// Turns each item into a job for the queue; depends on sdf_pkg.
module sdf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  input  sdf_pkg::sdf_in_t   in_item,
  input  logic               queue_full,
  output logic               push,
  output sdf_pkg::sdf_job_t  job
);

  logic [sdf_pkg::SIDE_W-1:0] image_side_r;
  logic [7:0]                 background_r;
  logic [sdf_pkg::SIDE_W-1:0] side;
  logic [sdf_pkg::SIDE_W-1:0] sum_x;
  logic [sdf_pkg::SIDE_W-1:0] sum_y;
  logic                       fits;
  logic                       mode_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_side_r <= sdf_pkg::SIDE_RESET;
      background_r <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == sdf_pkg::CFG_IMAGE_SIDE) begin
        image_side_r <= cfg_data;
      end else begin
        background_r <= cfg_data[7:0];
      end
    end
  end

  assign push = in_valid && !queue_full;

  always_comb begin
    if (image_side_r == '0) begin
      side = sdf_pkg::SIDE_W'(1);
    end else if (image_side_r > sdf_pkg::SIDE_W'(sdf_pkg::MAX_SIDE)) begin
      side = sdf_pkg::SIDE_W'(sdf_pkg::MAX_SIDE);
    end else begin
      side = image_side_r;
    end

    sum_x   = {1'b0, in_item.center_x} + {2'b00, in_item.half_size};
    sum_y   = {1'b0, in_item.center_y} + {2'b00, in_item.half_size};
    fits    = (in_item.center_x >= {1'b0, in_item.half_size})
           && (in_item.center_y >= {1'b0, in_item.half_size})
           && (sum_x < side) && (sum_y < side);
    mode_ok = (in_item.fill_mode == sdf_pkg::MODE_OUTLINE)
           || (in_item.fill_mode == sdf_pkg::MODE_FILLED);

    job         = '0;
    job.kind    = sdf_pkg::JOB_RESULT;
    job.status  = sdf_pkg::STATUS_DONE;
    job.x0      = in_item.center_x - {1'b0, in_item.half_size};
    job.y0      = in_item.center_y - {1'b0, in_item.half_size};
    job.x1      = sum_x[sdf_pkg::COORD_W-1:0];
    job.y1      = sum_y[sdf_pkg::COORD_W-1:0];
    job.level   = in_item.paint_level;
    job.outline = (in_item.fill_mode == sdf_pkg::MODE_OUTLINE);

    case (in_item.op)
      sdf_pkg::OP_CLEAR: begin
        job.kind    = sdf_pkg::JOB_PAINT;
        job.x0      = '0;
        job.y0      = '0;
        job.x1      = side[sdf_pkg::COORD_W-1:0] - 8'd1;
        job.y1      = side[sdf_pkg::COORD_W-1:0] - 8'd1;
        job.level   = background_r;
        job.outline = 1'b0;
      end
      sdf_pkg::OP_DRAW: begin
        if (!fits) begin
          job.status = sdf_pkg::STATUS_BOUNDS;
        end else if (!mode_ok) begin
          job.status = sdf_pkg::STATUS_MODE;
        end else begin
          job.kind = sdf_pkg::JOB_PAINT;
        end
      end
      sdf_pkg::OP_READ: begin
        job.x0 = in_item.center_x;
        job.y0 = in_item.center_y;
        if (({1'b0, in_item.center_x} < side) && ({1'b0, in_item.center_y} < side)) begin
          job.kind = sdf_pkg::JOB_READ;
        end else begin
          job.status = sdf_pkg::STATUS_BOUNDS;
        end
      end
      default: begin
        job.kind = sdf_pkg::JOB_RESULT;
      end
    endcase
  end

endmodule

// ===== sv/sdf_job_fifo.sv =====
// Short job queue between the front end and the pixel engine.
// Depends on sdf_pkg for the job type and depth.
module sdf_job_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdf_pkg::sdf_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output sdf_pkg::sdf_job_t head
);

  sdf_pkg::sdf_job_t           slots_r [sdf_pkg::QUEUE_DEPTH];
  logic [sdf_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [sdf_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [sdf_pkg::QCNT_W-1:0]  count_r;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count_r == sdf_pkg::QCNT_W'(sdf_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/sdf_back.sv =====
// Back end: pixel memory and the engine that sweeps paint jobs and reads.
// Holds the result register; depends on sdf_pkg.
module sdf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              queue_empty,
  input  sdf_pkg::sdf_job_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sdf_pkg::sdf_out_t out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAINT,
    S_READ,
    S_FINISH
  } state_t;

  logic [7:0] mem [sdf_pkg::STORE_DEPTH];

  state_t                      state_r, state_nxt;
  sdf_pkg::sdf_job_t           cur_r, cur_nxt;
  logic [sdf_pkg::COORD_W-1:0] x_r, x_nxt;
  logic [sdf_pkg::COORD_W-1:0] y_r, y_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sdf_pkg::sdf_out_t           out_item_r, out_item_nxt;
  logic [7:0]                  rd_data_r;
  logic                        out_free;
  logic                        on_edge;
  logic                        wr_en;
  logic                        rd_en;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign on_edge   = (x_r == cur_r.x0) || (x_r == cur_r.x1)
                  || (y_r == cur_r.y0) || (y_r == cur_r.y1);
  assign wr_en     = (state_r == S_PAINT) && (!cur_r.outline || on_edge);
  assign rd_en     = pop && (head.kind == sdf_pkg::JOB_READ);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{y_r, x_r}] <= cur_r.level;
    end
    if (rd_en) begin
      rd_data_r <= mem[{head.y0, head.x0}];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!queue_empty) begin
          case (head.kind)
            sdf_pkg::JOB_PAINT: begin
              pop       = 1'b1;
              cur_nxt   = head;
              x_nxt     = head.x0;
              y_nxt     = head.y0;
              state_nxt = S_PAINT;
            end
            sdf_pkg::JOB_READ: begin
              pop       = 1'b1;
              state_nxt = S_READ;
            end
            default: begin
              if (out_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{status: head.status, pixel_level: 8'd0};
              end
            end
          endcase
        end
      end
      S_PAINT: begin
        if (x_r == cur_r.x1) begin
          x_nxt = cur_r.x0;
          y_nxt = y_r + 1'b1;
          if (y_r == cur_r.y1) begin
            state_nxt = S_FINISH;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: sdf_pkg::STATUS_DONE, pixel_level: rd_data_r};
          state_nxt     = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: sdf_pkg::STATUS_DONE, pixel_level: 8'd0};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== sv/square_draw_framebuffer_top.sv =====
// Top level of the square-drawing framebuffer: front end, job queue, pixel engine.
// Depends on sdf_pkg, sdf_front, sdf_job_fifo and sdf_back.
//
//   channel  handshake              payload
//   in_      in_valid / in_stall    in_item   (sdf_pkg::sdf_in_t)
//   out_     out_valid / out_stall  out_item  (sdf_pkg::sdf_out_t)
//   cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Clear and draw sweep their square one pixel per cycle through the single write port
// of the pixel memory, then post the result from the finish state; a read posts the
// registered memory word from its read state and a rejected item its status from idle.
// The four-entry queue keeps taking items while the engine works.
// rst_n is synchronous; pixel contents are undefined until cleared or drawn.
// out_stall holds the result register and backs up the queue, then in_stall.
module square_draw_framebuffer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdf_pkg::sdf_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output sdf_pkg::sdf_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_data
);

  logic              queue_full;
  logic              queue_empty;
  logic              push;
  logic              pop;
  sdf_pkg::sdf_job_t push_job;
  sdf_pkg::sdf_job_t head;

  assign in_stall  = queue_full;
  assign cfg_ready = 1'b1;

  sdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  sdf_job_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head     (head)
  );

  sdf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
